// ===== src/tdt_pkg.sv =====
package tdt_pkg;

   // delimiter characters
   localparam logic [7:0] CH_TAG_OPEN   = 8'h7B;
   localparam logic [7:0] CH_TAG_CLOSE  = 8'h7D;
   localparam logic [7:0] CH_FILE_OPEN  = 8'h5B;
   localparam logic [7:0] CH_FILE_CLOSE = 8'h5D;
   localparam logic [7:0] CH_ESC_OPEN   = 8'h28;
   localparam logic [7:0] CH_ESC_CLOSE  = 8'h29;

   // input action codes
   localparam logic ACT_DATA  = 1'b0;
   localparam logic ACT_FLUSH = 1'b1;

   // result queue geometry
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_TEXT = 2'd1,
      KIND_TAG  = 2'd2,
      KIND_FILE = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] value;
      logic       last;
   } rsp_item_type;

   // up to two results produced by one request
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } step_out_type;

   function automatic rsp_item_type data_item(input logic [7:0] value);
      rsp_item_type item;
      item.kind  = KIND_DATA;
      item.value = value;
      item.last  = 1'b0;
      return item;
   endfunction

   function automatic rsp_item_type close_item(input kind_type kind);
      rsp_item_type item;
      item.kind  = kind;
      item.value = 8'h00;
      item.last  = 1'b0;
      return item;
   endfunction

endpackage

// ===== src/tdt_step.sv =====
module tdt_step (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic                  action,
   input  logic [7:0]            in_byte,
   output tdt_pkg::step_out_type step_out
);
   import tdt_pkg::*;

   typedef enum logic [9:0] {
      ST_TEXT            = 10'b00_0000_0001,
      ST_AFTER_TAG_OPEN  = 10'b00_0000_0010,
      ST_IN_TAG          = 10'b00_0000_0100,
      ST_AFTER_TAG_CLOSE = 10'b00_0000_1000,
      ST_AFTER_FILE_OPEN = 10'b00_0001_0000,
      ST_IN_FILE         = 10'b00_0010_0000,
      ST_AFTER_FILE_CLOSE= 10'b00_0100_0000,
      ST_AFTER_ESC_OPEN  = 10'b00_1000_0000,
      ST_IN_ESC          = 10'b01_0000_0000,
      ST_AFTER_ESC_CLOSE = 10'b10_0000_0000
   } state_type;

   state_type    state_ff, state_in;
   logic         pending_ff, pending_in;
   logic [1:0]   cnt;
   rsp_item_type item_a, item_b;

   // next state and results for the request in the input register
   always_comb begin
      state_in   = state_ff;
      pending_in = pending_ff;
      cnt        = 2'd0;
      item_a     = data_item(in_byte);
      item_b     = data_item(in_byte);
      if (action == ACT_FLUSH) begin
         if (pending_ff) begin
            item_a     = close_item(KIND_TEXT);
            cnt        = 2'd1;
            pending_in = 1'b0;
         end
      end else begin
         unique case (state_ff)
            ST_AFTER_TAG_OPEN: begin
               if (in_byte == CH_TAG_OPEN) begin
                  if (pending_ff) begin
                     item_a = close_item(KIND_TEXT);
                     cnt    = 2'd1;
                  end
                  pending_in = 1'b0;
                  state_in   = ST_IN_TAG;
               end else begin
                  item_a     = data_item(CH_TAG_OPEN);
                  cnt        = 2'd2;
                  pending_in = 1'b1;
                  state_in   = ST_TEXT;
               end
            end
            ST_IN_TAG: begin
               if (in_byte == CH_TAG_CLOSE) begin
                  state_in = ST_AFTER_TAG_CLOSE;
               end else begin
                  cnt        = 2'd1;
                  pending_in = 1'b1;
               end
            end
            ST_AFTER_TAG_CLOSE: begin
               // tag close goes out even for an empty tag
               if (in_byte == CH_TAG_CLOSE) begin
                  item_a     = close_item(KIND_TAG);
                  cnt        = 2'd1;
                  pending_in = 1'b0;
                  state_in   = ST_TEXT;
               end else begin
                  item_a     = data_item(CH_TAG_CLOSE);
                  cnt        = 2'd2;
                  pending_in = 1'b1;
                  state_in   = ST_IN_TAG;
               end
            end
            ST_AFTER_FILE_OPEN: begin
               if (in_byte == CH_FILE_OPEN) begin
                  if (pending_ff) begin
                     item_a = close_item(KIND_TEXT);
                     cnt    = 2'd1;
                  end
                  pending_in = 1'b0;
                  state_in   = ST_IN_FILE;
               end else begin
                  item_a     = data_item(CH_FILE_OPEN);
                  cnt        = 2'd2;
                  pending_in = 1'b1;
                  state_in   = ST_TEXT;
               end
            end
            ST_IN_FILE: begin
               if (in_byte == CH_FILE_CLOSE) begin
                  state_in = ST_AFTER_FILE_CLOSE;
               end else begin
                  cnt        = 2'd1;
                  pending_in = 1'b1;
               end
            end
            ST_AFTER_FILE_CLOSE: begin
               if (in_byte == CH_FILE_CLOSE) begin
                  if (pending_ff) begin
                     item_a = close_item(KIND_FILE);
                     cnt    = 2'd1;
                  end
                  pending_in = 1'b0;
                  state_in   = ST_TEXT;
               end else begin
                  item_a     = data_item(CH_FILE_CLOSE);
                  cnt        = 2'd2;
                  pending_in = 1'b1;
                  state_in   = ST_IN_FILE;
               end
            end
            ST_AFTER_ESC_OPEN: begin
               if (in_byte == CH_ESC_OPEN) begin
                  state_in = ST_IN_ESC;
               end else begin
                  item_a     = data_item(CH_ESC_OPEN);
                  cnt        = 2'd2;
                  pending_in = 1'b1;
                  state_in   = ST_TEXT;
               end
            end
            ST_IN_ESC: begin
               if (in_byte == CH_ESC_CLOSE) begin
                  state_in = ST_AFTER_ESC_CLOSE;
               end else begin
                  cnt        = 2'd1;
                  pending_in = 1'b1;
               end
            end
            ST_AFTER_ESC_CLOSE: begin
               if (in_byte == CH_ESC_CLOSE) begin
                  state_in = ST_TEXT;
               end else begin
                  item_a     = data_item(CH_ESC_CLOSE);
                  cnt        = 2'd2;
                  pending_in = 1'b1;
                  state_in   = ST_IN_ESC;
               end
            end
            default: begin
               // plain text
               priority if (in_byte == CH_TAG_OPEN) begin
                  state_in = ST_AFTER_TAG_OPEN;
               end else if (in_byte == CH_FILE_OPEN) begin
                  state_in = ST_AFTER_FILE_OPEN;
               end else if (in_byte == CH_ESC_OPEN) begin
                  state_in = ST_AFTER_ESC_OPEN;
               end else begin
                  cnt        = 2'd1;
                  pending_in = 1'b1;
                  state_in   = ST_TEXT;
               end
            end
         endcase
      end
      // mark the final result of this request
      if (cnt == 2'd1) begin
         item_a.last = 1'b1;
      end
      if (cnt == 2'd2) begin
         item_b.last = 1'b1;
      end
   end

   // parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_TEXT;
         pending_ff <= 1'b0;
      end else if (fire) begin
         state_ff   <= state_in;
         pending_ff <= pending_in;
      end
   end

   assign step_out.count  = fire ? cnt : 2'd0;
   assign step_out.first  = item_a;
   assign step_out.second = item_b;

   // a pair of results is always a lone delimiter and the byte after it
   assert property (@(posedge clock) disable iff (reset)
      (step_out.count == 2'd2) |->
         (item_a.kind == KIND_DATA && item_b.kind == KIND_DATA && item_b.last && !item_a.last))
      else $error("two-result request not a data pair");

   // any close item ends the segment
   assert property (@(posedge clock) disable iff (reset)
      (step_out.count == 2'd1 && item_a.kind != KIND_DATA) |=> !pending_ff)
      else $error("segment still pending after close");

   // close items never carry a byte
   assert property (@(posedge clock) disable iff (reset)
      (step_out.count != 2'd0 && item_a.kind != KIND_DATA) |-> (item_a.value == 8'h00))
      else $error("close item with nonzero byte");

   // end of buffer never moves the parse state
   assert property (@(posedge clock) disable iff (reset)
      (fire && action == ACT_FLUSH) |=> (state_ff == $past(state_ff)))
      else $error("end of buffer changed parse state");

endmodule

// ===== src/tdt_queue.sv =====
module tdt_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  tdt_pkg::step_out_type step_out,
   output logic                  room,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output tdt_pkg::rsp_item_type rsp_item
);
   import tdt_pkg::*;

   rsp_item_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]        count_ff, count_in;
   logic [QPTR_W-1:0]        wr_next;
   logic                     pop;

   // room for a full pair regardless of what leaves this cycle
   assign room      = (count_ff <= QCNT_W'(QUEUE_DEPTH - 2));
   assign rsp_valid = (count_ff != '0);
   assign rsp_item  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign wr_next   = wr_ptr_ff + QPTR_W'(1);

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(step_out.count);
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(step_out.count) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // result storage
   always_ff @(posedge clock) begin
      if (step_out.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= step_out.first;
      end
      if (step_out.count == 2'd2) begin
         entry_ff[wr_next] <= step_out.second;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("result queue overflow");

   assert property (@(posedge clock) disable iff (reset)
      (step_out.count != 2'd0) |-> room)
      else $error("push into queue without room");

   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |=> (count_ff <= QCNT_W'(2)))
      else $error("queue grew by more than one pair");

endmodule

// ===== src/template_delimiter_tokenizer.sv =====
// Byte tokenizer for templates: splits a byte stream into text, tag {{..}} and
// file [[..]] segments, drops the delimiters of escape regions ((..)), and emits
// one data item per segment byte plus close items (text and file closes only
// for non-empty segments, tag close always; an end-of-buffer request closes
// pending text). A request is taken into an input register, decoded there
// combinationally, and its one or two results are written into a four-entry
// result queue, so the first result is visible once the request has passed the
// input register and the queue. Requests are accepted every cycle while the
// queue holds at most two results; the output drains one result per cycle
// while rsp_ready is high, so a lone delimiter followed by another byte gives
// two results to drain. rsp_last_of_run marks each request's final result.
module template_delimiter_tokenizer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_action,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_item_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run
);
   import tdt_pkg::*;

   logic         in_valid_ff, in_valid_in;
   logic         in_action_ff;
   logic [7:0]   in_byte_ff;
   logic         room;
   logic         advance;
   logic         load;
   step_out_type step_out;
   rsp_item_type rsp_item;

   // input register hand-off
   assign advance     = in_valid_ff && room;
   assign req_ready   = !in_valid_ff || room;
   assign load        = req_valid && req_ready;
   assign in_valid_in = load || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         in_action_ff <= req_action;
         in_byte_ff   <= req_in_byte;
      end
   end

   tdt_step u_step (
      .clock    (clock),
      .reset    (reset),
      .fire     (advance),
      .action   (in_action_ff),
      .in_byte  (in_byte_ff),
      .step_out (step_out)
   );

   tdt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .step_out  (step_out),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   assign rsp_item_kind   = rsp_item.kind;
   assign rsp_out_byte    = rsp_item.value;
   assign rsp_last_of_run = rsp_item.last;

endmodule
